FILE: hdl/gmcp_pkg.sv
`timescale 1ns / 1ps
// shared constants and helpers for the grid minimum cost path core
package gmcp_pkg;

    // grid limits and widths
    localparam int unsigned MAX_COLS  = 1024;
    localparam int unsigned MAX_ROWS  = 1024;
    localparam int unsigned COST_BITS = 16;
    localparam int unsigned COL_W     = $clog2(MAX_COLS);
    localparam int unsigned ROW_W     = $clog2(MAX_ROWS);

    // fixed field widths
    localparam int unsigned IN_W   = 16;
    localparam int unsigned SUM_W  = 32;
    localparam int unsigned SIZE_W = 11;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_GRID_ROWS = 1'b0,
        REG_GRID_COLS = 1'b1
    } t_reg_idx;

    // size register value to last index: zero counts as one, oversize saturates
    function automatic logic [SIZE_W-1:0] size_to_last(input logic [SIZE_W-1:0] v,
                                                       input int unsigned limit);
        logic [SIZE_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (32'(v) > limit) begin
            res = SIZE_W'(limit - 1);
        end else begin
            res = v - 1'b1;
        end
        return res;
    endfunction

    // saturating add of two path costs
    function automatic logic [SUM_W-1:0] add_sat(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

FILE: hdl/grid_min_cost_path_core.sv
`timescale 1ns / 1ps
// grid minimum cost path core: row buffer memory, one cell per cycle unless the output slots are full
//
// Cell costs stream in on the s channel (tdata = cell_cost) in row-major
// order, one item per cell. After the last cell of a grid, one item on the
// m channel carries the least total cost from the top-left to the
// bottom-right cell (moves right, down, diagonal down-right).
// Grid size comes from the write port: index 0 = grid_rows, 1 = grid_cols,
// both 1..1024 (zero acts as one, larger values as 1024). Any write restarts
// the grid; write only while the core is idle.
// Throughput is one cell per cycle: each cell does one read of the row
// buffer memory (registered) and one write back of its best cost in the
// following cycle; with a single column the read is forwarded from
// the write. With the output idle, o_m_tvalid rises once the last cell's
// result leaves the compute stage for the head slot. Two output slots hold
// results, so one-cell grids also run back to back while the receiver keeps
// up; the final cell of a grid is held off only when both slots would still
// be taken, and the receiver stalling never blocks other cells.
// Reset clears control state and sets both sizes to one; the row buffer is
// not cleared, since each grid writes a row before reading it.
module grid_min_cost_path_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input cells
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [gmcp_pkg::IN_W-1:0] i_s_tdata,   // [15:0] cell_cost
    // results
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [gmcp_pkg::SUM_W-1:0] o_m_tdata,  // [31:0] path_cost
    // configuration writes
    input  logic                      i_cfg_we,
    input  logic [0:0]                i_cfg_index,
    input  logic [gmcp_pkg::SIZE_W-1:0] i_cfg_data
);
    import gmcp_pkg::*;

    // configuration
    logic [SIZE_W-1:0] r_grid_rows;
    logic [SIZE_W-1:0] r_grid_cols;
    logic [ROW_W-1:0]  w_rows_last;
    logic [COL_W-1:0]  w_cols_last;

    // position of the next cell
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic             w_col_end;
    logic             w_in_last;
    logic             w_accept;

    // compute stage
    logic                 r_s1_valid;
    logic                 r_s1_last;
    logic                 r_s1_has_up;
    logic                 r_s1_has_left;
    logic [COL_W-1:0]     r_s1_col;
    logic [COST_BITS-1:0] r_s1_cost;
    logic [SUM_W-1:0]     r_left;
    logic [SUM_W-1:0]     r_diag;
    logic [SUM_W-1:0]     w_up;
    logic [SUM_W-1:0]     w_least;
    logic [SUM_W-1:0]     w_best;

    // row buffer and forwarding
    logic [SUM_W-1:0] r_row_mem [MAX_COLS];
    logic [SUM_W-1:0] r_rd_data;
    logic             r_fwd;
    logic [SUM_W-1:0] r_fwd_data;

    // output slots
    logic             r_out_valid;
    logic [SUM_W-1:0] r_out_data;
    logic             r_hold_valid;
    logic [SUM_W-1:0] r_hold_data;
    logic             w_res_in;
    logic             w_res_pop;
    logic [1:0]       w_out_fill;
    logic             w_out_busy;

    // effective grid size
    assign w_rows_last = ROW_W'(size_to_last(r_grid_rows, MAX_ROWS));
    assign w_cols_last = COL_W'(size_to_last(r_grid_cols, MAX_COLS));

    // position bookkeeping
    assign w_col_end = (r_col == w_cols_last);
    assign w_in_last = w_col_end && (r_row == w_rows_last);

    always_comb begin
        n_row = r_row;
        n_col = r_col + 1'b1;
        if (w_col_end) begin
            n_col = '0;
            n_row = (r_row == w_rows_last) ? '0 : r_row + 1'b1;
        end
    end

    // results held after this edge; the final cell's result passes the compute stage before it lands in a slot
    assign w_res_in   = r_s1_valid && r_s1_last;
    assign w_res_pop  = r_out_valid && i_m_tready;
    assign w_out_fill = {1'b0, r_out_valid} + {1'b0, r_hold_valid} + {1'b0, w_res_in}
                      - {1'b0, w_res_pop};
    assign w_out_busy = (w_out_fill > 2'd1);
    assign o_s_tready = !w_in_last || !w_out_busy;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // configuration registers and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= SIZE_W'(1);
            r_grid_cols <= SIZE_W'(1);
            r_row       <= '0;
            r_col       <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_GRID_ROWS: r_grid_rows <= i_cfg_data;
                REG_GRID_COLS: r_grid_cols <= i_cfg_data;
                default:       r_grid_rows <= r_grid_rows;
            endcase
            r_row <= '0;
            r_col <= '0;
        end else if (w_accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // compute: least of the neighbors inside the grid plus own cost
    assign w_up = r_fwd ? r_fwd_data : (r_s1_has_up ? r_rd_data : '0);

    always_comb begin
        w_least = w_up;
        if (r_s1_has_left) begin
            if (!r_s1_has_up || r_left < w_least) begin
                w_least = r_left;
            end
            if (r_s1_has_up && r_diag < w_least) begin
                w_least = r_diag;
            end
        end
    end

    assign w_best = (r_s1_has_up || r_s1_has_left)
                  ? add_sat(w_least, SUM_W'(r_s1_cost))
                  : SUM_W'(r_s1_cost);

    // compute stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
        end else begin
            r_s1_valid <= w_accept && !i_cfg_we;
            r_s1_last  <= w_accept && !i_cfg_we && w_in_last;
        end
    end

    // compute stage payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_col      <= r_col;
            r_s1_cost     <= i_s_tdata[COST_BITS-1:0];
            r_s1_has_up   <= (r_row != '0);
            r_s1_has_left <= (r_col != '0);
        end
    end

    // neighbor costs carried along the row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_left <= '0;
            r_diag <= '0;
        end else if (r_s1_valid) begin
            r_left <= w_best;
            r_diag <= w_up;
        end
    end

    // row buffer: read on accept, write back in the next cycle from the compute stage
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_row_mem[r_s1_col] <= w_best;
        end
        if (w_accept) begin
            r_rd_data <= r_row_mem[r_col];
        end
    end

    // forward the write back when the next read hits the same entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (w_accept) begin
            r_fwd <= r_s1_valid && (r_s1_col == r_col) && (r_row != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_fwd_data <= w_best;
        end
    end

    // output slots: the head drives the m channel, the second slot takes
    // a result that arrives while the head still waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
        end else if (!r_out_valid || w_res_pop) begin
            r_out_valid  <= r_hold_valid || w_res_in;
            r_hold_valid <= r_hold_valid && w_res_in;
        end else if (w_res_in) begin
            r_hold_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_res_pop) begin
            r_out_data <= r_hold_valid ? r_hold_data : w_best;
        end
        if (w_res_in) begin
            r_hold_data <= w_best;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // a result never lands on a full pair of output slots
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_in && r_out_valid && !i_m_tready) |-> !r_hold_valid)
        else $error("result overwrote a pending output item");

    // forwarding only occurs on a single-column grid
    a_fwd_single_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> (r_s1_col == '0))
        else $error("forwarding outside a single-column grid");

    // the final cell of a grid returns the position to the top-left cell
    a_wrap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_in_last) |=> (r_row == '0 && r_col == '0))
        else $error("position did not wrap after the final cell");

endmodule
